/* rtl/bmpdec_pkg.sv */
// ----------------------------------------------------------------------------
// BMP palette decoder package
// Shared command and status types and result status codes.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

    localparam logic [2:0] STS_PIXEL      = 3'd0;
    localparam logic [2:0] STS_NOT_BMP    = 3'd1;
    localparam logic [2:0] STS_BAD_HDR    = 3'd2;
    localparam logic [2:0] STS_BAD_PLANES = 3'd3;
    localparam logic [2:0] STS_BAD_DEPTH  = 3'd4;
    localparam logic [2:0] STS_TOO_LARGE  = 3'd5;

    localparam logic [7:0] SIG_B      = 8'h42;
    localparam logic [7:0] SIG_M      = 8'h4D;
    localparam logic [31:0] HDR_OS2   = 32'd12;
    localparam logic [31:0] HDR_WIN   = 32'd40;
    localparam logic [5:0] FHDR_BYTES = 6'd14;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;   // capture the input byte
        logic parse;   // run the byte through the parser
        logic fetch;   // read one palette entry into the result register
        logic finish;  // close a pixel byte: padding count and row wrap
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err_out;   // the byte being parsed raises an error result
        logic pix_byte;  // the byte being parsed is a pixel-phase byte
        logic col_left;  // the current row still has columns to emit
        logic avail;     // another pixel is due from the current byte
        logic out_err;   // the result register holds an error result
    } sts_t;

endpackage

/* rtl/bmpdec_ctrl.sv */
// ----------------------------------------------------------------------------
// BMP palette decoder controller
// Sequences byte capture, parsing, palette reads and result transfers.
// ----------------------------------------------------------------------------
module bmpdec_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  bmpdec_pkg::sts_t   sts,
    output bmpdec_pkg::cmd_t   cmd
);
    import bmpdec_pkg::*;

    typedef enum logic [4:0] {
        CS_WAIT  = 5'b00001,
        CS_PARSE = 5'b00010,
        CS_FETCH = 5'b00100,
        CS_SHOW  = 5'b01000,
        CS_END   = 5'b10000
    } cstate_t;

    cstate_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CS_WAIT: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = CS_PARSE;
                end
            end
            CS_PARSE: begin
                cmd.parse = 1'b1;
                if (sts.err_out) begin
                    state_next = CS_SHOW;
                end else if (sts.pix_byte) begin
                    state_next = sts.col_left ? CS_FETCH : CS_END;
                end else begin
                    state_next = CS_WAIT;
                end
            end
            CS_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = CS_SHOW;
            end
            CS_SHOW: begin
                if (m_tready) begin
                    if (sts.out_err) begin
                        state_next = CS_WAIT;
                    end else if (sts.avail) begin
                        state_next = CS_FETCH;
                    end else begin
                        state_next = CS_END;
                    end
                end
            end
            CS_END: begin
                cmd.finish = 1'b1;
                state_next = CS_WAIT;
            end
            default: begin
                state_next = CS_WAIT;
            end
        endcase
    end

    assign s_tready = (state_reg == CS_WAIT);
    assign m_tvalid = (state_reg == CS_SHOW);

endmodule

/* rtl/bmpdec_datapath.sv */
// ----------------------------------------------------------------------------
// BMP palette decoder datapath
// Header parser, palette memory, pixel unpacker and result register.
// ----------------------------------------------------------------------------
module bmpdec_datapath #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  bmpdec_pkg::cmd_t   cmd,
    output bmpdec_pkg::sts_t   sts,
    output logic [47:0]        m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);
    import bmpdec_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(PALETTE_DEPTH);
    localparam int PIW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_FHDR = 6'b000010,
        PH_IHDR = 6'b000100,
        PH_PAL  = 6'b001000,
        PH_PIX  = 6'b010000,
        PH_IDLE = 6'b100000
    } phase_t;

    logic [23:0] pal_mem [PALETTE_DEPTH];

    logic [7:0]     byte_reg;
    logic           start_reg;
    phase_t         phase_reg, phase_next;
    logic [5:0]     bc_reg, bc_next;
    logic [31:0]    acc_reg, acc_next;
    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic           wbig_reg, wbig_next;
    logic           hbig_reg, hbig_next;
    logic [3:0]     bpp_reg, bpp_next;
    logic           cls_reg, cls_next;
    logic [PIW-1:0] pidx_reg, pidx_next;
    logic [WW-1:0]  col_reg, col_next;
    logic [HW-1:0]  line_reg, line_next;
    logic [1:0]     rbc_reg, rbc_next;
    logic [7:0]     sh_reg, sh_next;
    logic [3:0]     k_reg, k_next;

    logic [2:0]     out_status_reg;
    logic [WW-1:0]  out_col_reg;
    logic [HW-1:0]  out_line_reg;
    logic           out_last_reg;
    logic           out_done_reg;
    logic [23:0]    rgb_reg;

    logic           err;
    logic [2:0]     err_code;
    logic           pix_flag;
    logic           pal_we;
    logic [23:0]    pal_wdata;

    // Pixel unpacking helpers.
    logic [3:0]     npix;
    logic [7:0]     pix_idx;
    logic [7:0]     sh_shifted;
    logic           pix_last;
    logic           pix_done;
    logic [WW:0]    col_inc;

    always_comb begin
        unique case (bpp_reg)
            4'd1: begin
                npix = 4'd8; pix_idx = {7'd0, sh_reg[7]}; sh_shifted = {sh_reg[6:0], 1'b0};
            end
            4'd2: begin
                npix = 4'd4; pix_idx = {6'd0, sh_reg[7:6]}; sh_shifted = {sh_reg[5:0], 2'd0};
            end
            4'd4: begin
                npix = 4'd2; pix_idx = {4'd0, sh_reg[7:4]}; sh_shifted = {sh_reg[3:0], 4'd0};
            end
            default: begin
                npix = 4'd1; pix_idx = sh_reg; sh_shifted = 8'd0;
            end
        endcase
    end

    assign col_inc  = (WW + 1)'(col_reg) + (WW + 1)'(1);
    assign pix_done = (line_reg == '0) && (col_inc == (WW + 1)'(width_reg));
    assign pix_last = !(((k_reg + 4'd1) < npix) && (col_inc < (WW + 1)'(width_reg)));

    assign sts = '{
        err_out:  err,
        pix_byte: pix_flag,
        col_left: (col_reg < width_reg),
        avail:    (k_reg < npix) && (col_reg < width_reg),
        out_err:  (out_status_reg != STS_PIXEL)
    };

    // Parser next-state logic.
    always_comb begin
        phase_t      ph_b;
        logic [5:0]  o;
        logic [5:0]  w;
        logic [5:0]  s;
        logic [5:0]  len;
        logic        in_fld;
        logic [1:0]  pos;
        logic [31:0] v;
        logic        cmpl;
        logic        bpp_ok;
        logic [31:0] pal_acc;
        logic [1:0]  rbc_inc;

        phase_next  = phase_reg;
        bc_next     = bc_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        wbig_next   = wbig_reg;
        hbig_next   = hbig_reg;
        bpp_next    = bpp_reg;
        cls_next    = cls_reg;
        pidx_next   = pidx_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        rbc_next    = rbc_reg;
        sh_next     = sh_reg;
        k_next      = k_reg;
        err         = 1'b0;
        err_code    = STS_PIXEL;
        pal_we      = 1'b0;
        pal_wdata   = '0;
        pix_flag    = 1'b0;

        o = 6'd0; w = 6'd4; s = 6'd0; len = 6'd4; in_fld = 1'b0; pos = 2'd0;
        v = '0; cmpl = 1'b0; bpp_ok = 1'b0; pal_acc = '0; rbc_inc = 2'd0;
        ph_b = phase_reg;

        if (cmd.parse) begin
            // A start-of-file flag restarts the parser before this byte is taken.
            if (start_reg) begin
                ph_b        = PH_SIG;
                phase_next  = PH_SIG;
                bc_next     = '0;
                acc_next    = '0;
                width_next  = '0;
                height_next = '0;
                wbig_next   = 1'b0;
                hbig_next   = 1'b0;
                bpp_next    = '0;
                cls_next    = 1'b0;
                pidx_next   = '0;
                col_next    = '0;
                line_next   = '0;
                rbc_next    = '0;
            end

            unique case (ph_b)
                PH_SIG: begin
                    if (byte_reg != ((bc_next == 6'd0) ? SIG_B : SIG_M)) begin
                        err = 1'b1; err_code = STS_NOT_BMP;
                    end else begin
                        if (bc_next == 6'd1) begin
                            phase_next = PH_FHDR;
                        end
                        bc_next = bc_next + 6'd1;
                    end
                end
                PH_FHDR: begin
                    if (bc_next == FHDR_BYTES - 6'd1) begin
                        phase_next = PH_IHDR;
                        acc_next   = '0;
                    end
                    bc_next = bc_next + 6'd1;
                end
                PH_IHDR: begin
                    o = bc_next - FHDR_BYTES;
                    bc_next = bc_next + 6'd1;
                    w = cls_next ? 6'd2 : 6'd4;
                    priority if (o < 6'd4) begin
                        in_fld = 1'b1; s = 6'd0; len = 6'd4;
                    end else if (o < 6'd4 + w) begin
                        in_fld = 1'b1; s = 6'd4; len = w;
                    end else if (o < 6'd4 + 6'd2 * w) begin
                        in_fld = 1'b1; s = 6'd4 + w; len = w;
                    end else if (o < 6'd6 + 6'd2 * w) begin
                        in_fld = 1'b1; s = 6'd4 + 6'd2 * w; len = 6'd2;
                    end else if (o < 6'd8 + 6'd2 * w) begin
                        in_fld = 1'b1; s = 6'd6 + 6'd2 * w; len = 6'd2;
                    end else begin
                        in_fld = 1'b0;
                    end
                    pos  = 2'(o - s);
                    v    = acc_next | (32'(byte_reg) << {pos, 3'b000});
                    cmpl = in_fld && (o == s + len - 6'd1);
                    if (in_fld) begin
                        acc_next = cmpl ? 32'd0 : v;
                    end
                    bpp_ok = ((v == 32'd1) || (v == 32'd2) || (v == 32'd4) || (v == 32'd8))
                             && ((32'd1 << v[3:0]) <= 32'(PALETTE_DEPTH));
                    if (cmpl) begin
                        priority if (s == 6'd0) begin
                            if (v == HDR_OS2) begin
                                cls_next = 1'b1;
                            end else if (v == HDR_WIN) begin
                                cls_next = 1'b0;
                            end else begin
                                err = 1'b1; err_code = STS_BAD_HDR;
                            end
                        end else if (s == 6'd4) begin
                            width_next = WW'(v);
                            wbig_next  = (v > 32'(MAX_WIDTH));
                        end else if (s == 6'd4 + w) begin
                            height_next = HW'(v);
                            hbig_next   = (v > 32'(MAX_HEIGHT));
                        end else if (s == 6'd4 + 6'd2 * w) begin
                            if (v != 32'd1) begin
                                err = 1'b1; err_code = STS_BAD_PLANES;
                            end
                        end else begin
                            if (!bpp_ok) begin
                                err = 1'b1; err_code = STS_BAD_DEPTH;
                            end else begin
                                bpp_next = v[3:0];
                                if (wbig_next || hbig_next) begin
                                    err = 1'b1; err_code = STS_TOO_LARGE;
                                end
                            end
                        end
                    end
                    if (!err && (o == (cls_next ? 6'd11 : 6'd39))) begin
                        phase_next = PH_PAL;
                        pidx_next  = '0;
                        rbc_next   = '0;
                        acc_next   = '0;
                    end
                end
                PH_PAL: begin
                    pal_acc  = acc_next | (32'(byte_reg) << {rbc_next, 3'b000});
                    rbc_inc  = rbc_next + 2'd1;
                    acc_next = pal_acc;
                    rbc_next = rbc_inc;
                    if (rbc_inc == (cls_next ? 2'd3 : 2'd0)) begin
                        // Entry bytes arrive blue, green, red.
                        pal_we    = (32'(pidx_next) < 32'(PALETTE_DEPTH));
                        pal_wdata = pal_acc[23:0];
                        acc_next  = '0;
                        rbc_next  = '0;
                        if ((10'(pidx_next) + 10'd1) >= (10'd1 << bpp_next)) begin
                            if ((width_next == '0) || (height_next == '0)) begin
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_PIX;
                                col_next   = '0;
                                line_next  = height_next - HW'(1);
                            end
                        end
                        pidx_next = pidx_next + PIW'(1);
                    end
                end
                PH_PIX: begin
                    pix_flag = 1'b1;
                    sh_next  = byte_reg;
                    k_next   = '0;
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase

            if (err) begin
                phase_next = PH_IDLE;
            end
        end

        if (cmd.fetch) begin
            col_next = WW'(col_inc);
            k_next   = k_reg + 4'd1;
            sh_next  = sh_shifted;
        end

        if (cmd.finish) begin
            rbc_next = rbc_reg + 2'd1;
            if ((col_reg >= width_reg) && (rbc_next == 2'd0)) begin
                if (line_reg == '0) begin
                    phase_next = PH_IDLE;
                end else begin
                    line_next = line_reg - HW'(1);
                    col_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIG;
            bc_reg     <= '0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            wbig_reg   <= 1'b0;
            hbig_reg   <= 1'b0;
            bpp_reg    <= '0;
            cls_reg    <= 1'b0;
            pidx_reg   <= '0;
            col_reg    <= '0;
            line_reg   <= '0;
            rbc_reg    <= '0;
            k_reg      <= '0;
            out_status_reg <= STS_PIXEL;
        end else begin
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            wbig_reg   <= wbig_next;
            hbig_reg   <= hbig_next;
            bpp_reg    <= bpp_next;
            cls_reg    <= cls_next;
            pidx_reg   <= pidx_next;
            col_reg    <= col_next;
            line_reg   <= line_next;
            rbc_reg    <= rbc_next;
            k_reg      <= k_next;
            if (err) begin
                out_status_reg <= err_code;
            end else if (cmd.fetch) begin
                out_status_reg <= STS_PIXEL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
        sh_reg <= sh_next;
        if (err) begin
            out_col_reg  <= '0;
            out_line_reg <= '0;
            out_last_reg <= 1'b1;
            out_done_reg <= 1'b0;
        end else if (cmd.fetch) begin
            out_col_reg  <= col_reg;
            out_line_reg <= line_reg;
            out_last_reg <= pix_last;
            out_done_reg <= pix_done;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[pidx_reg[AW-1:0]] <= pal_wdata;
        end
        if (cmd.fetch) begin
            rgb_reg <= pal_mem[pix_idx[AW-1:0]];
        end
    end

    logic [31:0] col_wide;
    logic [31:0] line_wide;
    logic [23:0] rgb_out;

    assign col_wide  = 32'(out_col_reg);
    assign line_wide = 32'(out_line_reg);
    assign rgb_out   = (out_status_reg == STS_PIXEL) ? rgb_reg : 24'd0;

    assign m_tdata = {line_wide[11:0], col_wide[11:0],
                      rgb_out[7:0], rgb_out[15:8], rgb_out[23:16]};
    assign m_tuser = {out_done_reg, out_status_reg};
    assign m_tlast = out_last_reg;

endmodule

/* rtl/bmp_palette_image_decoder_core.sv */
// ----------------------------------------------------------------------------
// BMP palette image decoder core
// Decodes a byte stream of a palette BMP file into RGB pixels.
// ----------------------------------------------------------------------------
// The core takes a BMP file one byte per transfer, checks the signature,
// reads the OS/2 or Windows info header, stores the colour table in an
// internal memory and then unpacks the pixel rows, bottom row first, into one
// result transfer per pixel carrying its RGB colour, column and line. Header,
// palette and row padding bytes give no result. Each pixel of a pixel byte
// (up to eight at one bit per pixel) is read through the registered palette
// read port into the result register and held there while the result side
// stalls; the next byte is taken only once the last of them has gone.
// An error gives a single result with a non-zero status, after which bytes
// are ignored until one arrives with the start-of-file flag set.
// ----------------------------------------------------------------------------
module bmp_palette_image_decoder_core #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                   // [35:24] column, [47:36] line
    output logic [3:0]  m_tuser,   // [2:0] status, [3] image_done
    output logic        m_tlast    // last result caused by the input byte
);
    import bmpdec_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller hands out at most one command per cycle and waits on status.
    bmpdec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the parser state, the palette and the result register.
    bmpdec_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP palette image decoder testbench
// Streams whole BMP files into the decoder and checks every pixel transfer.
// ----------------------------------------------------------------------------
// Files are built in memory: a short table of hand-picked files (each header
// error, the one, two and four bit depths, both header formats and an empty
// image; error files stop at the byte that raises the error) and then a few
// small random files, some of them cut short or followed by noise. Every
// accepted byte goes through a behavioural decoder held here, which queues
// the pixel and error transfers it causes; each transfer from the core is
// compared field by field with the oldest of them. Both sides of the core
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import bmpdec_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and the core
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bmp_palette_image_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Behavioural decoder: its own copy of the parser state and colour table
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        PH_SIG, PH_FHDR, PH_IHDR, PH_PAL, PH_PIX, PH_IDLE
    } phase_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic        done;
    } pixel_t;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam int PAL_DEPTH = 256;

    // A random file whose final status is not known in advance.
    localparam logic [2:0] WANT_ANY = 3'd7;

    phase_t      phase;
    logic [31:0] offset;
    logic [31:0] accum;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] depth;
    logic        is_os2;
    logic [23:0] colours [PAL_DEPTH];
    logic [31:0] pal_pos;
    logic [31:0] col_pos;
    logic [31:0] row_pos;
    logic [1:0]  pad_count;

    pixel_t      pending_pixels [$];
    logic [2:0]  last_error;
    int          errors = 0;
    int          pixels_seen = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    bit          calm = 1'b0;   // when set, neither side idles

    task automatic restart_parser();
        phase = PH_SIG;
        offset = 0;
        accum = 0;
        img_w = 0;
        img_h = 0;
        depth = 0;
        is_os2 = 1'b0;
        pal_pos = 0;
        col_pos = 0;
        row_pos = 0;
        pad_count = 0;
    endtask

    task automatic raise_error(input logic [2:0] code);
        pixel_t r;
        r = '{status: code, red: 0, green: 0, blue: 0, column: 0, row: 0,
              last: 1'b1, done: 1'b0};
        pending_pixels.push_back(r);
        last_error = code;
        phase = PH_IDLE;
    endtask

    // Gathers one byte of a little-endian field at [first, first+len) and
    // returns 1 with the value once its last byte has arrived.
    function automatic bit gather_field(input logic [31:0] o, input int first,
                                        input int len, input logic [7:0] b,
                                        output logic [31:0] value);
        if (o < first || o >= first + len) return 1'b0;
        accum = accum | (32'(b) << (8 * (o - first)));
        if (o == first + len - 1) begin
            value = accum;
            accum = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic first_byte);
        logic [31:0] o;
        logic [31:0] v;
        int          wide;
        int          hsize;
        int          per_byte;
        int          k;
        logic [7:0]  idx;
        pixel_t      r;
        if (first_byte) restart_parser();
        case (phase)
            PH_SIG: begin
                if (b != (offset == 0 ? SIG_B : SIG_M)) begin
                    raise_error(STS_NOT_BMP);
                    return;
                end
                offset++;
                if (offset == 2) phase = PH_FHDR;
            end
            PH_FHDR: begin
                offset++;
                if (offset == 14) begin
                    phase = PH_IHDR;
                    accum = 0;
                end
            end
            PH_IHDR: begin
                o = offset - 14;
                offset++;
                if (o < 4) begin
                    if (gather_field(o, 0, 4, b, v)) begin
                        if (v == HDR_OS2) is_os2 = 1'b1;
                        else if (v == HDR_WIN) is_os2 = 1'b0;
                        else raise_error(STS_BAD_HDR);
                    end
                    return;
                end
                wide = is_os2 ? 2 : 4;
                hsize = is_os2 ? 12 : 40;
                if (gather_field(o, 4, wide, b, v)) img_w = v;
                if (gather_field(o, 4 + wide, wide, b, v)) img_h = v;
                if (gather_field(o, 4 + 2 * wide, 2, b, v) && v != 1) begin
                    raise_error(STS_BAD_PLANES);
                    return;
                end
                if (gather_field(o, 6 + 2 * wide, 2, b, v)) begin
                    if ((v != 1 && v != 2 && v != 4 && v != 8) || (1 << v) > PAL_DEPTH) begin
                        raise_error(STS_BAD_DEPTH);
                        return;
                    end
                    depth = v;
                    if (img_w > MAX_W || img_h > MAX_H) begin
                        raise_error(STS_TOO_LARGE);
                        return;
                    end
                end
                if (o == hsize - 1) begin
                    phase = PH_PAL;
                    pal_pos = 0;
                    pad_count = 0;
                    accum = 0;
                end
            end
            PH_PAL: begin
                // Colour table entries arrive as blue, green, red (and a pad
                // byte in the Windows format), so the low three bytes of the
                // accumulator already read as red in the top byte.
                accum = accum | (32'(b) << (8 * pad_count));
                pad_count++;
                if (pad_count == (is_os2 ? 3 : 0)) begin
                    if (pal_pos < PAL_DEPTH) colours[pal_pos] = accum[23:0];
                    pal_pos++;
                    accum = 0;
                    pad_count = 0;
                    if (depth == 0 || depth > 8 || pal_pos >= (1 << depth)) begin
                        if (img_w == 0 || img_h == 0) begin
                            phase = PH_IDLE;
                        end else begin
                            phase = PH_PIX;
                            col_pos = 0;
                            row_pos = img_h - 1;
                            pad_count = 0;
                        end
                    end
                end
            end
            PH_PIX: begin
                per_byte = 8 / depth;
                k = 0;
                while (k < per_byte && col_pos < img_w) begin
                    idx = 8'((b >> (8 - depth * (k + 1))) & ((1 << depth) - 1));
                    r.status = STS_PIXEL;
                    {r.red, r.green, r.blue} = colours[idx];
                    r.column = col_pos[11:0];
                    r.row = row_pos[11:0];
                    r.last = 1'b0;
                    r.done = (row_pos == 0 && col_pos + 1 == img_w);
                    pending_pixels.push_back(r);
                    col_pos++;
                    k++;
                end
                if (k > 0) pending_pixels[$].last = 1'b1;
                pad_count++;
                if (col_pos >= img_w && pad_count == 0) begin
                    if (row_pos == 0) begin
                        phase = PH_IDLE;
                    end else begin
                        row_pos--;
                        col_pos = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Checking of result transfers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge aclk) begin
        pixel_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 32);
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer data=%h user=%h",
                                              m_tdata, m_tuser));
                end else begin
                    e = pending_pixels.pop_front();
                    if (m_tuser[2:0] !== e.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser[2:0], e.status));
                    if (m_tdata[7:0] !== e.red || m_tdata[15:8] !== e.green ||
                        m_tdata[23:16] !== e.blue)
                        report_mismatch($sformatf("colour %h, expected %h%h%h",
                                                  m_tdata[23:0], e.blue, e.green, e.red));
                    if (m_tdata[35:24] !== e.column || m_tdata[47:36] !== e.row)
                        report_mismatch($sformatf("position %0d,%0d, expected %0d,%0d",
                                                  m_tdata[35:24], m_tdata[47:36],
                                                  e.column, e.row));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b, expected %b", m_tlast, e.last));
                    if (m_tuser[3] !== e.done)
                        report_mismatch($sformatf("image done %b, expected %b",
                                                  m_tuser[3], e.done));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // File building and byte transfers
    // ------------------------------------------------------------------------
    typedef struct {
        bit          os2;
        int          sig_fault;   // 0 good, 1 first byte wrong, 2 second wrong
        logic [31:0] hsize;
        logic [31:0] width;
        logic [31:0] height;
        int          planes;
        int          bpp;
        logic [2:0]  want;        // status the file must end with
        int          cut;         // bytes sent, 0 for the whole file
    } bmp_file_t;

    task automatic put_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) q.push_back(v[8 * i +: 8]);
    endtask

    task automatic build_bmp(input bmp_file_t f, ref logic [7:0] q[$]);
        int entries;
        int row_bytes;
        q.push_back(f.sig_fault == 1 ? 8'($urandom_range(0, 65)) : SIG_B);
        q.push_back(f.sig_fault == 2 ? 8'($urandom_range(78, 255)) : SIG_M);
        repeat (12) q.push_back(8'($urandom));
        put_le(q, f.hsize, 4);
        put_le(q, f.width, f.os2 ? 2 : 4);
        put_le(q, f.height, f.os2 ? 2 : 4);
        put_le(q, f.planes, 2);
        put_le(q, f.bpp, 2);
        if (!f.os2) repeat (24) q.push_back(8'($urandom));
        entries = (f.bpp inside {1, 2, 4, 8}) ? (1 << f.bpp) : 1;
        repeat (entries * (f.os2 ? 3 : 4)) q.push_back(8'($urandom));
        row_bytes = ((f.width * f.bpp + 31) / 32) * 4;
        if (f.want == STS_PIXEL && f.bpp inside {1, 2, 4, 8})
            repeat (row_bytes * f.height) q.push_back(8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first_byte);
        if (!calm && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first_byte;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, first_byte);
        bytes_sent++;
    endtask

    task automatic send_bmp(input bmp_file_t f, input int cut, input int noise);
        logic [7:0] q[$];
        build_bmp(f, q);
        if (cut > 0 && cut < q.size()) q = q[0:cut - 1];
        repeat (noise) q.push_back(8'($urandom));
        last_error = STS_PIXEL;
        foreach (q[i]) send_byte(q[i], i == 0);
        files_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    bmp_file_t directed [] = '{
        '{0, 0, 40, 9, 1, 1, 1, STS_PIXEL, 0},
        '{1, 0, 12, 3, 2, 1, 2, STS_PIXEL, 0},
        '{1, 0, 12, 3, 1, 1, 4, STS_PIXEL, 0},
        '{1, 0, 12, 0, 2, 1, 1, STS_PIXEL, 0},          // empty image
        '{0, 1, 40, 2, 2, 1, 1, STS_NOT_BMP, 1},
        '{0, 2, 40, 2, 2, 1, 1, STS_NOT_BMP, 2},
        '{0, 0, 20, 2, 2, 1, 1, STS_BAD_HDR, 18},
        '{1, 0, 12, 2, 2, 2, 1, STS_BAD_PLANES, 24},
        '{1, 0, 12, 2, 2, 1, 3, STS_BAD_DEPTH, 26},
        '{0, 0, 40, 4097, 2, 1, 8, STS_TOO_LARGE, 30},
        '{0, 0, 40, 2, 32'hFFFF_FFFF, 1, 1, STS_TOO_LARGE, 30},  // top-down height
        '{1, 0, 12, 65535, 1, 1, 1, STS_TOO_LARGE, 26}
    };

    initial begin
        bmp_file_t f;
        int depths [2] = '{1, 2};
        restart_parser();
        last_error = STS_PIXEL;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Hand-picked files: errors are checked against the table as well.
        // The first two pixel files run with no idling on either side.
        foreach (directed[i]) begin
            calm = (i < 2);
            send_bmp(directed[i], directed[i].cut, (i % 3 == 0) ? 3 : 0);
            if (last_error != directed[i].want)
                report_mismatch($sformatf("file %0d ended with status %0d, table says %0d",
                                          i, last_error, directed[i].want));
        end
        calm = 1'b0;

        // A few small random files.
        for (int n = 0; n < 3; n++) begin
            f.os2 = 1'b1;
            f.sig_fault = ($urandom_range(19) == 0) ? $urandom_range(1, 2) : 0;
            f.hsize = HDR_OS2;
            f.width = $urandom_range(1, 10);
            f.height = $urandom_range(1, 2);
            f.planes = ($urandom_range(19) == 0) ? $urandom_range(2, 9) : 1;
            f.bpp = depths[$urandom_range(1)];
            if ($urandom_range(19) == 0) f.bpp = $urandom_range(9, 31);
            f.want = (f.sig_fault || f.planes != 1 || f.bpp > 8) ? WANT_ANY : STS_PIXEL;
            // Some files are cut short and the next one restarts the parser.
            f.cut = ($urandom_range(7) == 0) ? $urandom_range(2, 40) : 0;
            send_bmp(f, f.cut, $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0);
        end
        s_tvalid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        foreach (pending_pixels[i])
            report_mismatch("transfer never arrived");

        $display("Run covered %0d files in %0d bytes and checked %0d result transfers.",
                 files_sent, bytes_sent, pixels_seen);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // A run that hangs is cut off here.
    initial begin
        #2ms;
        $display("timeout with %0d transfers outstanding", pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/bmpdec_pkg.sv
rtl/bmpdec_ctrl.sv
rtl/bmpdec_datapath.sv
rtl/bmp_palette_image_decoder_core.sv
tb/sv/testbench.sv
